[rtl/mbp_pkg.sv]
`default_nettype none

package mbp_pkg;

   // Function codes of an input item.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam int VALUE_W   = 64;
   localparam int WIDTH_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int PEND_W    = 7;
   localparam int CNT_W     = 3;
   // Bit string of one command: up to seven pending bits followed by 64 value bits.
   localparam int BITS_W    = PEND_W + VALUE_W;
   // Left-aligned emit buffer, a whole number of bytes.
   localparam int BUF_W     = 72;
   localparam int NBYTES_W  = 4;
   localparam int TOTAL_W   = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   typedef struct packed {
      logic [BITS_W-1:0]   bits;
      logic [TOTAL_W-1:0]  total;
      logic [NBYTES_W-1:0] nbytes;
      logic                error;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/mbp_front.sv]
`default_nettype none

module mbp_front #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic                        func,
   input  wire logic [mbp_pkg::VALUE_W-1:0] value,
   input  wire logic [mbp_pkg::WIDTH_W-1:0] width,
   output mbp_pkg::cmd_type                 cmd,
   output logic                             cmd_valid
);
   import mbp_pkg::*;

   localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

   logic [PEND_W-1:0]  pending_bits_ff, pending_bits_in;
   logic [CNT_W-1:0]   pending_count_ff, pending_count_in;

   logic [VALUE_W-1:0] over_mask;
   logic               bad;
   logic [BITS_W-1:0]  joined;
   logic [TOTAL_W-1:0] total;
   logic [CNT_W-1:0]   rem;
   logic [BYTE_W-1:0]  rem_mask;

   always_comb begin
      over_mask = ~((VALUE_W'(1) << width) - VALUE_W'(1));
      bad       = (width == '0) || (width > MAX_W) || ((value & over_mask) != '0);
      joined    = (BITS_W'(pending_bits_ff) << width) | BITS_W'(value);
      total     = TOTAL_W'(pending_count_ff) + width;
      rem       = total[CNT_W-1:0];
      rem_mask  = (BYTE_W'(1) << rem) - BYTE_W'(1);
   end

   always_comb begin
      cmd              = '0;
      cmd_valid        = 1'b0;
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      if (func == FUNC_FLUSH) begin
         cmd.bits         = BITS_W'(pending_bits_ff);
         cmd.total        = TOTAL_W'(pending_count_ff);
         cmd.nbytes       = NBYTES_W'(1);
         cmd_valid        = accept && (pending_count_ff != '0);
         pending_bits_in  = '0;
         pending_count_in = '0;
      end else if (bad) begin
         // A rejected write leaves the pending bits untouched.
         cmd.error  = 1'b1;
         cmd.nbytes = NBYTES_W'(1);
         cmd_valid  = accept;
      end else begin
         cmd.bits         = joined;
         cmd.total        = total;
         cmd.nbytes       = total[TOTAL_W-1:CNT_W];
         cmd_valid        = accept && (total[TOTAL_W-1:CNT_W] != '0);
         pending_bits_in  = joined[PEND_W-1:0] & rem_mask[PEND_W-1:0];
         pending_count_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
      end else if (accept) begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mbp_queue.sv]
`default_nettype none

module mbp_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire mbp_pkg::cmd_type push_data,
   output logic            full,
   input  wire logic       pop,
   output mbp_pkg::cmd_type pop_data,
   output logic            empty
);
   import mbp_pkg::*;

   cmd_type               mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
      pop_data  = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mbp_back.sv]
`default_nettype none

module mbp_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mbp_pkg::cmd_type           cmd,
   input  wire logic                       cmd_valid,
   output logic                            cmd_take,
   output logic                            empty,
   input  wire logic                       pop,
   output logic [mbp_pkg::BYTE_W-1:0]      out_byte,
   output logic                            last,
   output logic                            error
);
   import mbp_pkg::*;

   logic [BUF_W-1:0]    sr_ff, sr_in;
   logic [NBYTES_W-1:0] left_ff, left_in;
   logic                err_ff, err_in;
   logic                busy_ff, busy_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                out_last_ff, out_error_ff;

   logic                advance, emit, final_byte;
   logic [TOTAL_W-1:0]  align_shift;
   logic [BUF_W-1:0]    aligned;

   always_comb begin
      advance     = !out_valid_ff || pop;
      emit        = busy_ff && advance;
      final_byte  = (left_ff == NBYTES_W'(1));
      cmd_take    = cmd_valid && (!busy_ff || (emit && final_byte));
      // Move the first bit of the command to the top of the buffer; the
      // zeros shifted in below are the padding of a flush.
      align_shift = TOTAL_W'(BUF_W) - cmd.total;
      aligned     = BUF_W'(cmd.bits) << align_shift;

      out_valid_in = emit || (out_valid_ff && !pop);
      sr_in        = sr_ff;
      left_in      = left_ff;
      err_in       = err_ff;
      busy_in      = busy_ff;
      if (emit) begin
         sr_in   = sr_ff << BYTE_W;
         left_in = left_ff - NBYTES_W'(1);
         if (final_byte) begin
            busy_in = 1'b0;
         end
      end
      if (cmd_take) begin
         sr_in   = aligned;
         left_in = cmd.nbytes;
         err_in  = cmd.error;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      left_ff <= left_in;
      err_ff  <= err_in;
      if (emit) begin
         out_byte_ff  <= sr_ff[BUF_W-1 -: BYTE_W];
         out_last_ff  <= final_byte;
         out_error_ff <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign out_byte = out_byte_ff;
   assign last     = out_last_ff;
   assign error    = out_error_ff;

endmodule

`default_nettype wire

[rtl/msb_first_bit_packer_unit.sv]
`default_nettype none

// MSB-first bit packer. Each write transaction appends the low req_width bits of
// req_value, highest bit first, behind up to seven pending bits and returns one
// result per completed byte (first written bit in bit 7, rsp_last on the final
// one); a write that completes no byte returns nothing. A flush transaction pads
// the pending bits with zeros and returns that byte, or nothing if no bits are
// pending. A write with width 0, width above MAX_WIDTH or value bits set at or
// above the width returns one result with rsp_error set and rsp_out_byte zero,
// and leaves the pending bits unchanged. The front end classifies a request in
// the cycle it is accepted and places it in a two-entry command queue, so a
// request can be accepted every clock while the queue has room. The byte
// emitter behind the queue delivers one byte per clock through the output
// register as long as each result is popped when it appears, and a request
// completes at most 8 bytes. An accepted request passes through the command
// queue and the emitter's shift register before its first byte is output.
module msb_first_bit_packer_unit #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic                        req_func,
   input  wire logic [mbp_pkg::VALUE_W-1:0] req_value,
   input  wire logic [mbp_pkg::WIDTH_W-1:0] req_width,
   output logic                             empty,
   input  wire logic                        pop,
   output logic [mbp_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_last,
   output logic                             rsp_error
);
   import mbp_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    front_valid;
   logic    queue_full;
   logic    queue_empty;
   logic    back_take;
   logic    accept;

   assign full   = queue_full;
   assign accept = push && !queue_full;

   mbp_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .value    (req_value),
      .width    (req_width),
      .cmd      (front_cmd),
      .cmd_valid(front_valid)
   );

   mbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_data(front_cmd),
      .full     (queue_full),
      .pop      (back_take),
      .pop_data (queue_cmd),
      .empty    (queue_empty)
   );

   mbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (queue_cmd),
      .cmd_valid(!queue_empty),
      .cmd_take (back_take),
      .empty    (empty),
      .pop      (pop),
      .out_byte (rsp_out_byte),
      .last     (rsp_last),
      .error    (rsp_error)
   );

endmodule

`default_nettype wire

[rtl/mbp_checker.sv]
`default_nettype none

module mbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       rsp_error
);

   // Nothing is left queued or on the result ports after a reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not cleared by reset");

   // A waiting result that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_last)
                            && $stable(rsp_error)))
      else $error("waiting result changed");

   // A rejected transaction gives exactly one result with a zero byte.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error) |-> (rsp_last && (rsp_out_byte == 8'h00)))
      else $error("error result malformed");

   // A byte following a non-final byte belongs to the same transaction.
   a_error_run: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last) |=> (empty || !rsp_error))
      else $error("error result inside a byte run");

endmodule

bind msb_first_bit_packer_unit mbp_checker u_mbp_checker (
   .clock       (clock),
   .reset       (reset),
   .push        (push),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_out_byte(rsp_out_byte),
   .rsp_last    (rsp_last),
   .rsp_error   (rsp_error)
);

`default_nettype wire
